// ===== sv/rrts_pkg.sv =====
// Shared constants and types for the round-robin task scheduler.
package rrts_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int PID_COUNT  = 1024;
	localparam int PID_W      = $clog2(PID_COUNT);
	localparam int MAP_W      = 32;
	localparam int MAP_ROWS   = PID_COUNT / MAP_W;
	localparam int ROW_W      = $clog2(MAP_ROWS);
	localparam int BIT_W      = $clog2(MAP_W);
	localparam int ID_W       = 11;
	localparam int CNT_W      = SLOT_W + 1;

	// Event codes
	localparam logic [2:0] MODE_CREATE   = 3'd0;
	localparam logic [2:0] MODE_SCHEDULE = 3'd1;
	localparam logic [2:0] MODE_BLOCK    = 3'd2;
	localparam logic [2:0] MODE_UNBLOCK  = 3'd3;
	localparam logic [2:0] MODE_YIELD    = 3'd4;
	localparam logic [2:0] MODE_EXIT     = 3'd5;

	// Error codes
	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_BAD_STATE = 2'd1;
	localparam logic [1:0] ERR_NO_PID    = 2'd2;
	localparam logic [1:0] ERR_NONE_RUN  = 2'd3;

	// Task states
	localparam logic [2:0] TS_RUNNING = 3'd0;
	localparam logic [2:0] TS_READY   = 3'd1;
	localparam logic [2:0] TS_BLOCKED = 3'd2;
	localparam logic [2:0] TS_WAITING = 3'd3;
	localparam logic [2:0] TS_HANGING = 3'd4;
	localparam logic [2:0] TS_DIED    = 3'd5;

	localparam logic [1:0] KIND_MAX = 2'd2;

	// Register indexes
	localparam logic CFG_PID_BASE  = 1'b0;
	localparam logic CFG_IDLE_TASK = 1'b1;

	typedef enum logic [1:0] {
		Q_NONE,
		Q_APPEND,
		Q_PUSH,
		Q_REMOVE
	} qop_t;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_CHECK    = 10'b0000000010,
		ST_SCAN_RD  = 10'b0000000100,
		ST_SCAN_CHK = 10'b0000001000,
		ST_CLR_RD   = 10'b0000010000,
		ST_CLR_WR   = 10'b0000100000,
		ST_D0       = 10'b0001000000,
		ST_D1       = 10'b0010000000,
		ST_D2       = 10'b0100000000,
		ST_DONE     = 10'b1000000000
	} seq_state_t;

endpackage

// ===== sv/round_robin_task_scheduler_unit.sv =====
// Round-robin task scheduler: sequencer, task tables, linked ready queue and id map.
// Create scans the id map one 32-bit row at a time through its read port (ST_SCAN_RD, ST_SCAN_CHK).
// Schedule, block and yield pick the next task in ST_D0..ST_D2; unblock finishes in ST_CHECK;
// exit frees the id in ST_CLR_RD and ST_CLR_WR and then reschedules if asked.
// One event at a time; the next request is taken once the result is in the output register.
// Reset clears all control state, marks every slot died and every id map row free at once.
module round_robin_task_scheduler_unit
	import rrts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [PID_W-1:0]    cfg_wdata,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [2:0]          mode,
	input  logic [SLOT_W-1:0]   task_slot,
	input  logic [7:0]          priority_req,
	input  logic [1:0]          block_kind,
	input  logic                start_running,
	input  logic                exit_resched,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [1:0]          error_code,
	output logic                switched,
	output logic [SLOT_W-1:0]   prev_task,
	output logic [SLOT_W-1:0]   next_task,
	output logic [7:0]          next_priority,
	output logic [ID_W-1:0]     new_pid
);

	seq_state_t state_q, state_d;

	logic [PID_W-1:0]  pid_base_q;
	logic [SLOT_W-1:0] idle_q;

	logic [2:0]        mode_q;
	logic [SLOT_W-1:0] slot_q;
	logic [7:0]        prio_q;
	logic [1:0]        kind_q;
	logic              start_q, resched_q;

	logic [SLOT_W-1:0] rd_addr_q, rd_addr_d;
	logic [SLOT_W-1:0] cur_q, cur_d, head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	logic [2:0]        tstate_q [TASK_SLOTS];
	logic [7:0]        tprio_q  [TASK_SLOTS];
	logic [ID_W-1:0]   tid_q    [TASK_SLOTS];
	logic [SLOT_W-1:0] qnext_q  [TASK_SLOTS];
	logic [SLOT_W-1:0] qprev_q  [TASK_SLOTS];

	logic [2:0]        st_rd;
	logic [7:0]        pr_rd;
	logic [ID_W-1:0]   id_rd;
	logic [SLOT_W-1:0] nx_rd, pv_rd;

	logic              st_we;
	logic [SLOT_W-1:0] st_wa;
	logic [2:0]        st_wd;
	logic              cr_we;
	logic [ID_W-1:0]   cr_id;

	qop_t              qop;
	logic [SLOT_W-1:0] qs;
	logic              nx_we, pv_we;
	logic [SLOT_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

	logic [MAP_W-1:0]  map_mem [MAP_ROWS];
	logic [MAP_ROWS-1:0] row_vld_q;
	logic [MAP_W-1:0]  map_word_q;
	logic              map_rv_q;
	logic [ROW_W-1:0]  map_row_q, map_row_d;
	logic [BIT_W-1:0]  map_bit_q, map_bit_d;
	logic              clr_ok_q, clr_ok_d;
	logic              map_we;
	logic [MAP_W-1:0]  map_wdata;
	logic [MAP_W-1:0]  scan_word;
	logic              scan_found;
	logic [BIT_W-1:0]  scan_pos;
	logic [ID_W:0]     id_diff;

	logic [1:0]        res_err_q, res_err_d;
	logic              res_sw_q, res_sw_d;
	logic [SLOT_W-1:0] res_prev_q, res_prev_d, res_next_q, res_next_d;
	logic [7:0]        res_prio_q, res_prio_d;
	logic [ID_W-1:0]   res_pid_q, res_pid_d;

	logic              rsp_valid_q;
	logic [1:0]        err_q;
	logic              sw_q;
	logic [SLOT_W-1:0] prev_q, next_q;
	logic [7:0]        nprio_q;
	logic [ID_W-1:0]   pid_q;

	logic req_acc, rsp_load;

	function automatic logic is_blk(input logic [2:0] st);
		return st == TS_BLOCKED || st == TS_WAITING || st == TS_HANGING;
	endfunction

	assign req_stall = state_q != ST_IDLE;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_load  = state_q == ST_DONE && (!rsp_valid_q || !rsp_stall);

	assign st_rd = tstate_q[rd_addr_q];
	assign pr_rd = tprio_q[rd_addr_q];
	assign id_rd = tid_q[rd_addr_q];
	assign nx_rd = qnext_q[rd_addr_q];
	assign pv_rd = qprev_q[rd_addr_q];

	// Lowest free id in the fetched row; a row never written is all free.
	assign scan_word = map_rv_q ? map_word_q : '0;
	always_comb begin
		scan_found = ~&scan_word;
		scan_pos   = '0;
		for (int i = MAP_W - 1; i >= 0; i--) begin
			if (!scan_word[i]) scan_pos = BIT_W'(i);
		end
	end

	assign id_diff = {1'b0, id_rd} - {{(ID_W + 1 - PID_W){1'b0}}, pid_base_q};

	// Linked-list unit: one queue operation per cycle
	always_comb begin
		nx_we  = 1'b0;
		pv_we  = 1'b0;
		nx_wa  = tail_q;
		nx_wd  = qs;
		pv_wa  = qs;
		pv_wd  = tail_q;
		head_d = head_q;
		tail_d = tail_q;
		cnt_d  = cnt_q;
		case (qop)
			Q_APPEND: begin
				if (cnt_q == '0) begin
					head_d = qs;
				end else begin
					nx_we = 1'b1;
					pv_we = 1'b1;
				end
				tail_d = qs;
				cnt_d  = cnt_q + 1'b1;
			end
			Q_PUSH: begin
				if (cnt_q == '0) begin
					tail_d = qs;
				end else begin
					pv_we = 1'b1;
					pv_wa = head_q;
					pv_wd = qs;
					nx_we = 1'b1;
					nx_wa = qs;
					nx_wd = head_q;
				end
				head_d = qs;
				cnt_d  = cnt_q + 1'b1;
			end
			Q_REMOVE: begin
				if (cnt_q == CNT_W'(1)) begin
					cnt_d = '0;
				end else if (cnt_q != '0) begin
					if (qs == head_q) begin
						head_d = nx_rd;
					end else begin
						nx_we = 1'b1;
						nx_wa = pv_rd;
						nx_wd = nx_rd;
					end
					if (qs == tail_q) begin
						tail_d = pv_rd;
					end else begin
						pv_we = 1'b1;
						pv_wa = nx_rd;
						pv_wd = pv_rd;
					end
					cnt_d = cnt_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_comb begin
		state_d    = state_q;
		rd_addr_d  = rd_addr_q;
		cur_d      = cur_q;
		map_row_d  = map_row_q;
		map_bit_d  = map_bit_q;
		clr_ok_d   = clr_ok_q;
		res_err_d  = res_err_q;
		res_sw_d   = res_sw_q;
		res_prev_d = res_prev_q;
		res_next_d = res_next_q;
		res_prio_d = res_prio_q;
		res_pid_d  = res_pid_q;
		qop        = Q_NONE;
		qs         = rd_addr_q;
		st_we      = 1'b0;
		st_wa      = rd_addr_q;
		st_wd      = TS_READY;
		cr_we      = 1'b0;
		cr_id      = ID_W'({map_row_q, scan_pos}) + ID_W'(pid_base_q);
		map_we     = 1'b0;
		map_wdata  = scan_word | (MAP_W'(1) << scan_pos);
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					rd_addr_d = (mode == MODE_CREATE || mode == MODE_UNBLOCK ||
						mode == MODE_EXIT) ? task_slot : cur_q;
					res_err_d  = ERR_OK;
					res_sw_d   = 1'b0;
					res_prev_d = '0;
					res_next_d = '0;
					res_prio_d = '0;
					res_pid_d  = '0;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_DONE;
				case (mode_q)
					MODE_CREATE: begin
						if (st_rd != TS_DIED) begin
							res_err_d = ERR_BAD_STATE;
						end else begin
							map_row_d = '0;
							state_d   = ST_SCAN_RD;
						end
					end
					MODE_SCHEDULE: state_d = ST_D0;
					MODE_BLOCK: begin
						if (kind_q > KIND_MAX || st_rd != TS_RUNNING) begin
							res_err_d = ERR_BAD_STATE;
						end else begin
							st_we   = 1'b1;
							st_wd   = 3'(kind_q) + TS_BLOCKED;
							state_d = ST_D0;
						end
					end
					MODE_UNBLOCK: begin
						if (!is_blk(st_rd)) begin
							res_err_d = ERR_BAD_STATE;
						end else begin
							qop   = Q_PUSH;
							st_we = 1'b1;
						end
					end
					MODE_YIELD: begin
						if (st_rd != TS_RUNNING) res_err_d = ERR_BAD_STATE;
						else state_d = ST_D0;
					end
					MODE_EXIT: begin
						if (st_rd == TS_DIED) begin
							res_err_d = ERR_BAD_STATE;
						end else begin
							if (st_rd == TS_READY) qop = Q_REMOVE;
							st_we     = 1'b1;
							st_wd     = TS_DIED;
							map_row_d = id_diff[PID_W-1:BIT_W];
							map_bit_d = id_diff[BIT_W-1:0];
							clr_ok_d  = id_diff < (ID_W + 1)'(PID_COUNT);
							rd_addr_d = cur_q;
							state_d   = ST_CLR_RD;
						end
					end
					default: ;
				endcase
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (scan_found) begin
					map_we    = 1'b1;
					cr_we     = 1'b1;
					res_pid_d = cr_id;
					st_we     = 1'b1;
					st_wa     = slot_q;
					if (start_q) begin
						st_wd = TS_RUNNING;
						cur_d = slot_q;
					end else begin
						qop = Q_APPEND;
						qs  = slot_q;
					end
					state_d = ST_DONE;
				end else if (map_row_q == ROW_W'(MAP_ROWS - 1)) begin
					res_err_d = ERR_NO_PID;
					state_d   = ST_DONE;
				end else begin
					map_row_d = map_row_q + 1'b1;
					state_d   = ST_SCAN_RD;
				end
			end
			ST_CLR_RD: state_d = ST_CLR_WR;
			ST_CLR_WR: begin
				map_we    = clr_ok_q;
				map_wdata = scan_word & ~(MAP_W'(1) << map_bit_q);
				state_d   = resched_q ? ST_D0 : ST_DONE;
			end
			ST_D0: begin
				res_prev_d = cur_q;
				if (st_rd == TS_RUNNING) begin
					qop   = Q_APPEND;
					st_we = 1'b1;
				end
				rd_addr_d = idle_q;
				state_d   = ST_D1;
			end
			ST_D1: begin
				// queue empty: wake the idle task if it sleeps, else nothing runs
				if (cnt_q == '0) begin
					if (is_blk(st_rd)) begin
						qop       = Q_PUSH;
						st_we     = 1'b1;
						rd_addr_d = idle_q;
						state_d   = ST_D2;
					end else begin
						res_err_d  = ERR_NONE_RUN;
						res_prev_d = '0;
						state_d    = ST_DONE;
					end
				end else begin
					rd_addr_d = head_q;
					state_d   = ST_D2;
				end
			end
			ST_D2: begin
				qop        = Q_REMOVE;
				st_we      = 1'b1;
				st_wd      = TS_RUNNING;
				cur_d      = rd_addr_q;
				res_sw_d   = 1'b1;
				res_next_d = rd_addr_q;
				res_prio_d = pr_rd;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pid_base_q  <= PID_W'(1);
			idle_q      <= '0;
			cur_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			row_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < TASK_SLOTS; i++) tstate_q[i] <= TS_DIED;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			if (cfg_we) begin
				if (cfg_index == CFG_PID_BASE) pid_base_q <= cfg_wdata;
				else idle_q <= cfg_wdata[SLOT_W-1:0];
			end
			if (st_we) tstate_q[st_wa] <= st_wd;
			if (map_we) row_vld_q[map_row_q] <= 1'b1;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// Payload and tables
	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q    <= mode;
			slot_q    <= task_slot;
			prio_q    <= priority_req;
			kind_q    <= block_kind;
			start_q   <= start_running;
			resched_q <= exit_resched;
		end
		rd_addr_q  <= rd_addr_d;
		map_row_q  <= map_row_d;
		map_bit_q  <= map_bit_d;
		clr_ok_q   <= clr_ok_d;
		res_err_q  <= res_err_d;
		res_sw_q   <= res_sw_d;
		res_prev_q <= res_prev_d;
		res_next_q <= res_next_d;
		res_prio_q <= res_prio_d;
		res_pid_q  <= res_pid_d;
		if (cr_we) begin
			tprio_q[slot_q] <= prio_q;
			tid_q[slot_q]   <= cr_id;
		end
		if (nx_we) qnext_q[nx_wa] <= nx_wd;
		if (pv_we) qprev_q[pv_wa] <= pv_wd;
		if (rsp_load) begin
			err_q   <= res_err_q;
			sw_q    <= res_sw_q;
			prev_q  <= res_prev_q;
			next_q  <= res_next_q;
			nprio_q <= res_prio_q;
			pid_q   <= res_pid_q;
		end
	end

	// Id map memory
	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_row_q] <= map_wdata;
		map_word_q <= map_mem[map_row_q];
		map_rv_q   <= row_vld_q[map_row_q];
	end

	assign rsp_valid     = rsp_valid_q;
	assign error_code    = err_q;
	assign switched      = sw_q;
	assign prev_task     = prev_q;
	assign next_task     = next_q;
	assign next_priority = nprio_q;
	assign new_pid       = pid_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TASK_SLOTS))
		else $error("ready queue count beyond slot count");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q == ST_CHECK)
		else $error("accepted transaction did not start");

	a_err_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && err_q != ERR_OK |-> !sw_q)
		else $error("error reported together with a switch");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_D2 |-> cnt_q != '0)
		else $error("pop from an empty ready queue");

endmodule

// ===== sim/round_robin_task_scheduler_unit_tb.sv =====
// Self-checking testbench for the round-robin task scheduler unit.
module round_robin_task_scheduler_unit_tb;
	import rrts_pkg::*;

	typedef struct packed {
		logic [1:0]        err;
		logic              sw;
		logic [SLOT_W-1:0] prev;
		logic [SLOT_W-1:0] nxt;
		logic [7:0]        prio;
		logic [ID_W-1:0]   pid;
	} sched_result_t;

	typedef struct {
		logic [2:0]        md;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        prio;
		logic [1:0]        kind;
		logic              start;
		logic              resched;
		logic              typed;
		sched_result_t     res;
	} event_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [PID_W-1:0]    cfg_wdata;
	logic                req_valid;
	logic                req_stall;
	logic [2:0]          mode;
	logic [SLOT_W-1:0]   task_slot;
	logic [7:0]          priority_req;
	logic [1:0]          block_kind;
	logic                start_running;
	logic                exit_resched;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [1:0]          error_code;
	logic                switched;
	logic [SLOT_W-1:0]   prev_task;
	logic [SLOT_W-1:0]   next_task;
	logic [7:0]          next_priority;
	logic [ID_W-1:0]     new_pid;

	round_robin_task_scheduler_unit dut (.*);

	// Shadow copy of the scheduler state
	logic [PID_W-1:0]  sh_pid_base;
	logic [SLOT_W-1:0] sh_idle;
	logic [2:0]        sh_state [TASK_SLOTS];
	logic [7:0]        sh_prio [TASK_SLOTS];
	logic [ID_W-1:0]   sh_id [TASK_SLOTS];
	logic [SLOT_W-1:0] sh_next [TASK_SLOTS];
	logic [SLOT_W-1:0] sh_prev [TASK_SLOTS];
	logic [SLOT_W-1:0] sh_head, sh_tail, sh_cur;
	int                sh_count;
	bit                sh_used [PID_COUNT];

	sched_result_t expected_q [$];
	int  errors = 0;
	int  n_results = 0;
	int  n_switches = 0;
	int  n_err [4];
	longint cycles = 0;
	bit  rsp_random = 1;

	function automatic bit is_sleeping(logic [2:0] st);
		return st == TS_BLOCKED || st == TS_WAITING || st == TS_HANGING;
	endfunction

	function automatic void ready_append(logic [SLOT_W-1:0] s);
		if (sh_count == 0) sh_head = s;
		else begin
			sh_next[sh_tail] = s;
			sh_prev[s] = sh_tail;
		end
		sh_tail = s;
		sh_count++;
	endfunction

	function automatic void ready_push(logic [SLOT_W-1:0] s);
		if (sh_count == 0) sh_tail = s;
		else begin
			sh_prev[sh_head] = s;
			sh_next[s] = sh_head;
		end
		sh_head = s;
		sh_count++;
	endfunction

	function automatic void ready_unlink(logic [SLOT_W-1:0] s);
		if (sh_count == 0) return;
		if (sh_count == 1) begin
			sh_count = 0;
			return;
		end
		if (s == sh_head) sh_head = sh_next[s];
		else sh_next[sh_prev[s]] = sh_next[s];
		if (s == sh_tail) sh_tail = sh_prev[s];
		else sh_prev[sh_next[s]] = sh_prev[s];
		sh_count--;
	endfunction

	function automatic void pick_next(ref sched_result_t r);
		logic [SLOT_W-1:0] c, n;
		c = sh_cur;
		if (sh_state[c] == TS_RUNNING) begin
			ready_append(c);
			sh_state[c] = TS_READY;
		end
		if (sh_count == 0 && is_sleeping(sh_state[sh_idle])) begin
			ready_push(sh_idle);
			sh_state[sh_idle] = TS_READY;
		end
		if (sh_count == 0) begin
			r.err = ERR_NONE_RUN;
			return;
		end
		n = sh_head;
		ready_unlink(n);
		sh_state[n] = TS_RUNNING;
		sh_cur = n;
		r.sw = 1'b1;
		r.prev = c;
		r.nxt = n;
		r.prio = sh_prio[n];
	endfunction

	function automatic sched_result_t schedule_event(event_row_t e);
		sched_result_t r;
		int i;
		logic [ID_W-1:0] idx;
		r = '0;
		case (e.md)
			MODE_CREATE: begin
				if (sh_state[e.slot] != TS_DIED) r.err = ERR_BAD_STATE;
				else begin
					for (i = 0; i < PID_COUNT; i++) if (!sh_used[i]) break;
					if (i >= PID_COUNT) r.err = ERR_NO_PID;
					else begin
						sh_used[i] = 1;
						sh_id[e.slot] = ID_W'(i) + ID_W'(sh_pid_base);
						sh_prio[e.slot] = e.prio;
						if (e.start) begin
							sh_state[e.slot] = TS_RUNNING;
							sh_cur = e.slot;
						end else begin
							sh_state[e.slot] = TS_READY;
							ready_append(e.slot);
						end
						r.pid = sh_id[e.slot];
					end
				end
			end
			MODE_SCHEDULE: pick_next(r);
			MODE_BLOCK: begin
				if (e.kind > KIND_MAX || sh_state[sh_cur] != TS_RUNNING) r.err = ERR_BAD_STATE;
				else begin
					sh_state[sh_cur] = 3'(e.kind) + TS_BLOCKED;
					pick_next(r);
				end
			end
			MODE_UNBLOCK: begin
				if (!is_sleeping(sh_state[e.slot])) r.err = ERR_BAD_STATE;
				else begin
					ready_push(e.slot);
					sh_state[e.slot] = TS_READY;
				end
			end
			MODE_YIELD: begin
				if (sh_state[sh_cur] != TS_RUNNING) r.err = ERR_BAD_STATE;
				else pick_next(r);
			end
			MODE_EXIT: begin
				if (sh_state[e.slot] == TS_DIED) r.err = ERR_BAD_STATE;
				else begin
					if (sh_state[e.slot] == TS_READY) ready_unlink(e.slot);
					sh_state[e.slot] = TS_DIED;
					idx = sh_id[e.slot] - ID_W'(sh_pid_base);
					if (idx < PID_COUNT) sh_used[idx] = 0;
					if (e.resched) pick_next(r);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Response side: random stall and compare
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			sched_result_t got, want;
			got = '{error_code, switched, prev_task, next_task, next_priority, new_pid};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				n_results++;
				n_err[got.err]++;
				if (got.sw) n_switches++;
				if (got.err !== want.err) begin
					$display("%0t: error_code exp %0d got %0d", $time, want.err, got.err);
					errors++;
				end
				if (got.sw !== want.sw) begin
					$display("%0t: switched exp %0d got %0d", $time, want.sw, got.sw);
					errors++;
				end
				if (got.prev !== want.prev) begin
					$display("%0t: prev_task exp %0d got %0d", $time, want.prev, got.prev);
					errors++;
				end
				if (got.nxt !== want.nxt) begin
					$display("%0t: next_task exp %0d got %0d", $time, want.nxt, got.nxt);
					errors++;
				end
				if (got.prio !== want.prio) begin
					$display("%0t: next_priority exp %0d got %0d", $time, want.prio, got.prio);
					errors++;
				end
				if (got.pid !== want.pid) begin
					$display("%0t: new_pid exp %0d got %0d", $time, want.pid, got.pid);
					errors++;
				end
			end
		end
		if (!rsp_random) rsp_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 60) rsp_stall <= 1'b0;
		else if ($urandom_range(0, 9) == 0) rsp_stall <= 1'b1;
		else rsp_stall <= ($urandom_range(0, 2) != 0);
	end

	task automatic wait_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		repeat (g) @(posedge clk);
	endtask

	task automatic send_event(event_row_t e);
		sched_result_t r;
		r = schedule_event(e);
		expected_q.push_back(e.typed ? e.res : r);
		if (e.typed && e.res !== r)
			$display("%0t: note: table row disagrees with shadow model", $time);
		req_valid <= 1'b1;
		mode <= e.md;
		task_slot <= e.slot;
		priority_req <= e.prio;
		block_kind <= e.kind;
		start_running <= e.start;
		exit_resched <= e.resched;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		// drop valid and let the deasserted value reach the DUT before the next transaction is driven
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [PID_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PID_BASE) sh_pid_base = val;
		else sh_idle = val[SLOT_W-1:0];
		@(posedge clk);
	endtask

	function automatic event_row_t mk(logic [2:0] md, int slot, int prio, int kind,
			bit start, bit resched);
		event_row_t e;
		e.md = md;
		e.slot = SLOT_W'(slot);
		e.prio = 8'(prio);
		e.kind = 2'(kind);
		e.start = start;
		e.resched = resched;
		e.typed = 0;
		e.res = '0;
		return e;
	endfunction

	function automatic event_row_t mkx(event_row_t e, logic [1:0] err, logic [ID_W-1:0] pid);
		e.typed = 1;
		e.res = '0;
		e.res.err = err;
		e.res.pid = pid;
		return e;
	endfunction

	function automatic event_row_t rand_event(bit clean);
		event_row_t e;
		int r;
		e = mk(MODE_SCHEDULE, $urandom_range(0, 15), $urandom_range(0, 255),
			$urandom_range(0, 3), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		r = $urandom_range(0, 99);
		if (!clean) e.md = 3'($urandom_range(0, 7));
		else if (r < 25) e.md = MODE_CREATE;
		else if (r < 40) e.md = MODE_SCHEDULE;
		else if (r < 55) e.md = MODE_BLOCK;
		else if (r < 70) e.md = MODE_UNBLOCK;
		else if (r < 82) e.md = MODE_YIELD;
		else e.md = MODE_EXIT;
		if (clean) begin
			if (e.kind == 3) e.kind = 2'($urandom_range(0, 2));
			e.start = ($urandom_range(0, 3) == 0);
		end
		return e;
	endfunction

	initial begin
		event_row_t table_rows [$];
		int k, n;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_wdata = '0;
		req_valid = 0;
		mode = '0;
		task_slot = '0;
		priority_req = '0;
		block_kind = '0;
		start_running = 0;
		exit_resched = 0;
		rsp_stall = 0;
		sh_pid_base = 1;
		sh_idle = 0;
		sh_head = 0;
		sh_tail = 0;
		sh_cur = 0;
		sh_count = 0;
		for (k = 0; k < TASK_SLOTS; k++) begin
			sh_state[k] = TS_DIED;
			sh_prio[k] = 0;
			sh_id[k] = 0;
			sh_next[k] = 0;
			sh_prev[k] = 0;
		end
		for (k = 0; k < PID_COUNT; k++) sh_used[k] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed rows; error rows and pid values right after reset are typed in
		table_rows.push_back(mkx(mk(MODE_SCHEDULE, 0, 0, 0, 0, 0), ERR_NONE_RUN, 0));
		table_rows.push_back(mkx(mk(MODE_YIELD, 0, 0, 0, 0, 0), ERR_BAD_STATE, 0));
		table_rows.push_back(mkx(mk(MODE_BLOCK, 0, 0, 0, 0, 0), ERR_BAD_STATE, 0));
		table_rows.push_back(mkx(mk(MODE_EXIT, 15, 0, 0, 0, 1), ERR_BAD_STATE, 0));
		table_rows.push_back(mkx(mk(MODE_UNBLOCK, 3, 0, 0, 0, 0), ERR_BAD_STATE, 0));
		table_rows.push_back(mkx(mk(MODE_CREATE, 0, 255, 0, 1, 0), ERR_OK, 1));
		table_rows.push_back(mkx(mk(MODE_CREATE, 15, 0, 0, 0, 0), ERR_OK, 2));
		table_rows.push_back(mkx(mk(MODE_CREATE, 0, 7, 0, 0, 0), ERR_BAD_STATE, 0));
		table_rows.push_back(mk(MODE_YIELD, 0, 0, 0, 0, 0));
		table_rows.push_back(mkx(mk(MODE_BLOCK, 0, 0, 3, 0, 0), ERR_BAD_STATE, 0));
		table_rows.push_back(mk(MODE_BLOCK, 0, 0, 2, 0, 0));
		table_rows.push_back(mk(MODE_UNBLOCK, 15, 0, 0, 0, 0));
		table_rows.push_back(mk(MODE_BLOCK, 0, 0, 1, 0, 0));
		table_rows.push_back(mk(MODE_BLOCK, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(MODE_SCHEDULE, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(MODE_CREATE, 7, 170, 0, 1, 0));
		table_rows.push_back(mk(MODE_EXIT, 7, 0, 0, 0, 1));
		table_rows.push_back(mk(MODE_EXIT, 0, 0, 0, 0, 0));
		table_rows.push_back(mk(6, 5, 85, 1, 1, 1));
		table_rows.push_back(mk(7, 10, 170, 2, 0, 0));
		foreach (table_rows[i]) begin
			send_event(table_rows[i]);
			wait_gap();
		end
		drain();

		// Phase settings, extremes included; each phase is mostly clean sequences
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_IDLE_TASK, 15); write_reg(CFG_PID_BASE, 0); end
				1: begin write_reg(CFG_IDLE_TASK, 3); write_reg(CFG_PID_BASE, 1023); end
				2: write_reg(CFG_PID_BASE, 512);
				3: begin write_reg(CFG_IDLE_TASK, 0); write_reg(CFG_PID_BASE, 5); end
				4: write_reg(CFG_PID_BASE, PID_W'($urandom_range(0, 1023)));
				default: write_reg(CFG_IDLE_TASK, PID_W'($urandom_range(0, 15)));
			endcase
			rsp_random = (ph != 2);
			n = 90;
			for (k = 0; k < n; k++) begin
				send_event(rand_event($urandom_range(0, 9) != 0));
				if (ph != 4) wait_gap();
				if (k == 45) begin
					while (expected_q.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		$display("Covered %0d results: %0d switches; errors ok/state/pid/none = %0d/%0d/%0d/%0d",
			n_results, n_switches, n_err[0], n_err[1], n_err[2], n_err[3]);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
